@@ sv/segint_pkg.sv @@
// ============================================================================
// Segment intersect package
// Shared payload types, pipeline record types and sizing constants.
// ============================================================================
package segint_pkg;

  // Number of quotient bits produced by the divider (magnitude clamp is 2^40).
  localparam int unsigned QuotBits = 41;
  // Width of the divisor and of the partial remainder (2 * |det|).
  localparam int unsigned DivBits  = 68;

  typedef struct packed {
    logic signed [31:0] seg0_ax;
    logic signed [31:0] seg0_ay;
    logic signed [31:0] seg0_bx;
    logic signed [31:0] seg0_by;
    logic signed [31:0] seg1_ax;
    logic signed [31:0] seg1_ay;
    logic signed [31:0] seg1_bx;
    logic signed [31:0] seg1_by;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               parallel;
  } out_t;

  // Widened containment bounds of the four ranges.
  typedef struct packed {
    logic signed [32:0] x0_lo;
    logic signed [32:0] x0_hi;
    logic signed [32:0] x1_lo;
    logic signed [32:0] x1_hi;
    logic signed [32:0] y0_lo;
    logic signed [32:0] y0_hi;
    logic signed [32:0] y1_lo;
    logic signed [32:0] y1_hi;
  } bnd_t;

  // One divider lane: remainder, shifting dividend/quotient word, divisor.
  typedef struct packed {
    logic [DivBits-1:0]  rem;
    logic [QuotBits-1:0] sh;
    logic [DivBits-1:0]  dvs;
    logic                ovf;
    logic                neg;
  } lane_t;

  typedef struct packed {
    lane_t lx;
    lane_t ly;
    logic  par;
    bnd_t  bnd;
  } pipe_t;

endpackage

@@ sv/segment_segment_intersect_core.sv @@
// ============================================================================
// Segment against segment intersection core
// Exact fixed-point crossing of two segments with a tolerance window.
// ============================================================================
// The core takes one segment pair per clock while not stalled and returns one
// result per pair, in order, through eight front stages that form
// directions, line constants, the determinant and the two numerators with
// multipliers of at most 33 by 34 bits, 41 restoring-divider steps (one
// quotient bit per stage, x and y lanes side by side) and two back stages
// for clamping, the containment test and saturation. The whole pipeline
// advances together; it holds only while a result sits in the output
// register and the consumer stalls, so the sustained rate is one transfer
// per cycle while unstalled. The first stages read the tolerance register,
// so the user must write it only while no item is in flight (not enforced).
// ============================================================================
module segment_segment_intersect_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  segint_pkg::in_t   in_data_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output segint_pkg::out_t  out_data_o,
  // Tolerance register write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [30:0]       cfg_data_i
);
  import segint_pkg::*;

  logic [30:0] tol_q;
  logic        en;

  logic  front_valid;
  pipe_t front_pipe;
  logic  div_valid [QuotBits+1];
  pipe_t div_pipe  [QuotBits+1];

  // Every stage moves when the output register is free or being drained.
  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  segint_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .tol_i   (tol_q),
    .valid_o (front_valid),
    .pipe_o  (front_pipe)
  );

  assign div_valid[0] = front_valid;
  assign div_pipe[0]  = front_pipe;

  // One stage per quotient bit, most significant bit first.
  for (genvar g = 0; g < QuotBits; g++) begin : g_div
    segint_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .pipe_i  (div_pipe[g]),
      .valid_o (div_valid[g+1]),
      .pipe_o  (div_pipe[g+1])
    );
  end

  segint_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid[QuotBits]),
    .pipe_i  (div_pipe[QuotBits]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

@@ sv/segint_front.sv @@
// ============================================================================
// Segment intersect front end
// Eight register stages: directions, line constants, determinant, numerators
// and the setup of the rounded division.
// ============================================================================
module segint_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  segint_pkg::in_t     data_i,
  input  logic [30:0]         tol_i,
  output logic                valid_o,
  output segint_pkg::pipe_t   pipe_o
);
  import segint_pkg::*;

  logic [8:1] v_q;

  // Stage 1
  logic signed [31:0] ax0_q, ay0_q, ax1_q, ay1_q;
  logic signed [32:0] dx0_q, dy0_q, dx1_q, dy1_q;
  logic signed [31:0] mn_q [4];
  logic signed [31:0] mx_q [4];
  // Stage 2
  logic signed [64:0] pa0_q, pb0_q, pa1_q, pb1_q;
  logic signed [65:0] pd0_q, pd1_q;
  logic signed [32:0] dx0_2q, dy0_2q, dx1_2q, dy1_2q;
  bnd_t               bnd2_q, bnd3_q, bnd4_q, bnd5_q, bnd6_q, bnd7_q;
  // Stage 3
  logic signed [65:0] e0_q, e1_q;
  logic signed [66:0] det3_q, det4_q, det5_q, det6_q;
  logic signed [32:0] dx0_3q, dy0_3q, dx1_3q, dy1_3q;
  // Stage 4: partial products on the low and high halves of e
  logic signed [66:0] al_q, bl_q, cl_q, dl_q;
  logic signed [65:0] ah_q, bh_q, ch_q, dh_q;
  // Stage 5
  logic signed [99:0] a_q, b_q, c_q, d_q;
  // Stage 6
  logic signed [99:0] nx_q, ny_q;
  // Stage 7
  logic [99:0] absx_q, absy_q;
  logic [66:0] absd_q;
  logic        negx_q, negy_q, par_q;
  // Stage 8
  pipe_t       pipe_q;

  logic [100:0] nx_full, ny_full;
  logic [DivBits-1:0] dvs;
  logic [DivBits-1:0] topx, topy;
  logic               ovfx, ovfy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1
      ax0_q <= data_i.seg0_ax;
      ay0_q <= data_i.seg0_ay;
      ax1_q <= data_i.seg1_ax;
      ay1_q <= data_i.seg1_ay;
      dx0_q <= 33'(data_i.seg0_bx) - 33'(data_i.seg0_ax);
      dy0_q <= 33'(data_i.seg0_by) - 33'(data_i.seg0_ay);
      dx1_q <= 33'(data_i.seg1_bx) - 33'(data_i.seg1_ax);
      dy1_q <= 33'(data_i.seg1_by) - 33'(data_i.seg1_ay);
      mn_q[0] <= (data_i.seg0_ax < data_i.seg0_bx) ? data_i.seg0_ax : data_i.seg0_bx;
      mx_q[0] <= (data_i.seg0_ax < data_i.seg0_bx) ? data_i.seg0_bx : data_i.seg0_ax;
      mn_q[1] <= (data_i.seg1_ax < data_i.seg1_bx) ? data_i.seg1_ax : data_i.seg1_bx;
      mx_q[1] <= (data_i.seg1_ax < data_i.seg1_bx) ? data_i.seg1_bx : data_i.seg1_ax;
      mn_q[2] <= (data_i.seg0_ay < data_i.seg0_by) ? data_i.seg0_ay : data_i.seg0_by;
      mx_q[2] <= (data_i.seg0_ay < data_i.seg0_by) ? data_i.seg0_by : data_i.seg0_ay;
      mn_q[3] <= (data_i.seg1_ay < data_i.seg1_by) ? data_i.seg1_ay : data_i.seg1_by;
      mx_q[3] <= (data_i.seg1_ay < data_i.seg1_by) ? data_i.seg1_by : data_i.seg1_ay;

      // Stage 2
      pa0_q  <= 65'(dy0_q) * 65'(ax0_q);
      pb0_q  <= 65'(dx0_q) * 65'(ay0_q);
      pa1_q  <= 65'(dy1_q) * 65'(ax1_q);
      pb1_q  <= 65'(dx1_q) * 65'(ay1_q);
      pd0_q  <= 66'(dx0_q) * 66'(dy1_q);
      pd1_q  <= 66'(dy0_q) * 66'(dx1_q);
      dx0_2q <= dx0_q;
      dy0_2q <= dy0_q;
      dx1_2q <= dx1_q;
      dy1_2q <= dy1_q;
      bnd2_q.x0_lo <= 33'(mn_q[0]) - $signed({2'b00, tol_i});
      bnd2_q.x0_hi <= 33'(mx_q[0]) + $signed({2'b00, tol_i});
      bnd2_q.x1_lo <= 33'(mn_q[1]) - $signed({2'b00, tol_i});
      bnd2_q.x1_hi <= 33'(mx_q[1]) + $signed({2'b00, tol_i});
      bnd2_q.y0_lo <= 33'(mn_q[2]) - $signed({2'b00, tol_i});
      bnd2_q.y0_hi <= 33'(mx_q[2]) + $signed({2'b00, tol_i});
      bnd2_q.y1_lo <= 33'(mn_q[3]) - $signed({2'b00, tol_i});
      bnd2_q.y1_hi <= 33'(mx_q[3]) + $signed({2'b00, tol_i});

      // Stage 3: line constants e = dy*ax - dx*ay and the determinant.
      e0_q   <= 66'(pa0_q) - 66'(pb0_q);
      e1_q   <= 66'(pa1_q) - 66'(pb1_q);
      det3_q <= 67'(pd0_q) - 67'(pd1_q);
      dx0_3q <= dx0_2q;
      dy0_3q <= dy0_2q;
      dx1_3q <= dx1_2q;
      dy1_3q <= dy1_2q;
      bnd3_q <= bnd2_q;

      // Stage 4: e split into an unsigned low half and a signed high half.
      al_q   <= 67'(dx0_3q) * $signed({34'b0, e1_q[32:0]});
      ah_q   <= 66'(dx0_3q) * 66'($signed(e1_q[65:33]));
      bl_q   <= 67'(dx1_3q) * $signed({34'b0, e0_q[32:0]});
      bh_q   <= 66'(dx1_3q) * 66'($signed(e0_q[65:33]));
      cl_q   <= 67'(dy0_3q) * $signed({34'b0, e1_q[32:0]});
      ch_q   <= 66'(dy0_3q) * 66'($signed(e1_q[65:33]));
      dl_q   <= 67'(dy1_3q) * $signed({34'b0, e0_q[32:0]});
      dh_q   <= 66'(dy1_3q) * 66'($signed(e0_q[65:33]));
      det4_q <= det3_q;
      bnd4_q <= bnd3_q;

      // Stage 5: recombine the halves.
      a_q    <= $signed({ah_q[65], ah_q, 33'b0}) + $signed({{33{al_q[66]}}, al_q});
      b_q    <= $signed({bh_q[65], bh_q, 33'b0}) + $signed({{33{bl_q[66]}}, bl_q});
      c_q    <= $signed({ch_q[65], ch_q, 33'b0}) + $signed({{33{cl_q[66]}}, cl_q});
      d_q    <= $signed({dh_q[65], dh_q, 33'b0}) + $signed({{33{dl_q[66]}}, dl_q});
      det5_q <= det4_q;
      bnd5_q <= bnd4_q;

      // Stage 6: numerators of the crossing coordinates.
      nx_q   <= a_q - b_q;
      ny_q   <= c_q - d_q;
      det6_q <= det5_q;
      bnd6_q <= bnd5_q;

      // Stage 7: signs and magnitudes.
      absx_q <= nx_q[99] ? 100'(-nx_q) : 100'(nx_q);
      absy_q <= ny_q[99] ? 100'(-ny_q) : 100'(ny_q);
      absd_q <= det6_q[66] ? 67'(-det6_q) : 67'(det6_q);
      negx_q <= nx_q[99] ^ det6_q[66];
      negy_q <= ny_q[99] ^ det6_q[66];
      par_q  <= (det6_q == '0);
      bnd7_q <= bnd6_q;

      // Stage 8
      pipe_q <= {lane_x_setup(), lane_y_setup(), par_q, bnd7_q};
    end
  end

  // Rounded quotient (2|n| + |d|) / (2|d|): dividend and divisor setup.
  always_comb begin
    nx_full = {absx_q, 1'b0} + {34'b0, absd_q};
    ny_full = {absy_q, 1'b0} + {34'b0, absd_q};
    dvs     = {absd_q, 1'b0};
    topx    = {8'b0, nx_full[100:QuotBits]};
    topy    = {8'b0, ny_full[100:QuotBits]};
    ovfx    = (topx >= dvs);
    ovfy    = (topy >= dvs);
  end

  function automatic lane_t lane_x_setup();
    lane_t l;
    l.rem = ovfx ? '0 : topx;
    l.sh  = nx_full[QuotBits-1:0];
    l.dvs = dvs;
    l.ovf = ovfx;
    l.neg = negx_q;
    return l;
  endfunction

  function automatic lane_t lane_y_setup();
    lane_t l;
    l.rem = ovfy ? '0 : topy;
    l.sh  = ny_full[QuotBits-1:0];
    l.dvs = dvs;
    l.ovf = ovfy;
    l.neg = negy_q;
    return l;
  endfunction

  assign valid_o = v_q[8];
  assign pipe_o  = pipe_q;

endmodule

@@ sv/segint_div_step.sv @@
// ============================================================================
// Segment intersect divider step
// One registered restoring-division step for both coordinate lanes.
// ============================================================================
module segint_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  segint_pkg::pipe_t pipe_i,
  output logic              valid_o,
  output segint_pkg::pipe_t pipe_o
);
  import segint_pkg::*;

  logic  valid_q;
  pipe_t pipe_q;
  pipe_t pipe_d;

  function automatic lane_t step(lane_t l);
    lane_t          r;
    logic [DivBits:0] t;
    logic           ge;
    t     = {l.rem, l.sh[QuotBits-1]};
    ge    = (t >= {1'b0, l.dvs});
    r     = l;
    r.rem = ge ? DivBits'(t - {1'b0, l.dvs}) : t[DivBits-1:0];
    r.sh  = {l.sh[QuotBits-2:0], ge};
    return r;
  endfunction

  always_comb begin
    pipe_d    = pipe_i;
    pipe_d.lx = step(pipe_i.lx);
    pipe_d.ly = step(pipe_i.ly);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

@@ sv/segint_back.sv @@
// ============================================================================
// Segment intersect back end
// Clamp and sign of the quotients, containment test, saturation and the
// output register.
// ============================================================================
module segint_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  segint_pkg::pipe_t pipe_i,
  output logic              valid_o,
  output segint_pkg::out_t  data_o
);
  import segint_pkg::*;

  logic               v1_q, v2_q;
  logic signed [41:0] vx_q, vy_q;
  logic               par_q;
  bnd_t               bnd_q;
  out_t               out_q;

  logic signed [41:0] vx_d, vy_d;
  logic               hit;

  function automatic logic signed [41:0] signed_quot(lane_t l);
    logic        clamp;
    logic [40:0] m;
    clamp = l.ovf | (l.sh[40] & (|l.sh[39:0]));
    m     = clamp ? {1'b1, 40'b0} : l.sh;
    return l.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic in_rng(logic signed [41:0] v, logic signed [32:0] lo,
                                  logic signed [32:0] hi);
    return (v >= 42'(lo)) && (v <= 42'(hi));
  endfunction

  function automatic logic [31:0] sat32(logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -42'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  assign vx_d = signed_quot(pipe_i.lx);
  assign vy_d = signed_quot(pipe_i.ly);

  assign hit = in_rng(vx_q, bnd_q.x0_lo, bnd_q.x0_hi) && in_rng(vx_q, bnd_q.x1_lo, bnd_q.x1_hi)
            && in_rng(vy_q, bnd_q.y0_lo, bnd_q.y0_hi) && in_rng(vy_q, bnd_q.y1_lo, bnd_q.y1_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q  <= vx_d;
      vy_q  <= vy_d;
      par_q <= pipe_i.par;
      bnd_q <= pipe_i.bnd;
      out_q.hit      <= !par_q && hit;
      out_q.cross_x  <= par_q ? '0 : sat32(vx_q);
      out_q.cross_y  <= par_q ? '0 : sat32(vy_q);
      out_q.parallel <= par_q;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

endmodule

@@ bench/segment_segment_intersect_core_test.sv @@
// ============================================================================
// Segment intersection core testbench
// Drives segment pairs through the valid/stall input channel and checks every
// result against a cycle-free exact-arithmetic predictor. The tolerance
// register is swept while the pipeline is empty.
// ============================================================================
`timescale 1ns / 100ps

module segment_segment_intersect_core_test;
  import segint_pkg::*;

  // Wide signed type for the exact line arithmetic (numerators need 100 bits).
  typedef logic signed [127:0] wide_t;

  localparam int unsigned PipeDepth  = 51;
  localparam int unsigned DrainWait  = PipeDepth + 20;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam logic [30:0] TolMax     = 31'h7FFF_FFFF;
  localparam logic [30:0] TolOne     = 31'd65536;
  localparam logic signed [31:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [31:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [63:0] LimitMag = 64'sd1 <<< 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i;

  segment_segment_intersect_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Expected crossings in transfer order, and the bench's copy of the register.
  out_t        expected_crossings[$];
  logic [30:0] tol_shadow;

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned hits_seen;
  int unsigned parallels_seen;
  int unsigned idle_cycles;

  // Idling switches for each side; the quiet stretch turns both off.
  bit send_idle_en;
  bit recv_idle_en;

  // Long receiver hold-off request: the test bumps hold_req, the receiver
  // process notices the change and counts the stretch down itself.
  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor. The two lines are written as dy*x - dx*y = e and intersected by
  // Cramer's rule. The quotient is rounded to nearest with ties away from zero,
  // its magnitude limited to 2^40 for the containment test, and only the
  // reported coordinates are saturated to 32 bits.
  // --------------------------------------------------------------------------
  function automatic logic signed [63:0] round_quotient(wide_t num, wide_t den);
    logic         neg;
    logic [127:0] mag_n;
    logic [127:0] mag_d;
    logic [127:0] q;
    logic signed [63:0] m;
    neg   = num[127] ^ den[127];
    mag_n = num[127] ? -num : num;
    mag_d = den[127] ? -den : den;
    q     = (mag_n * 2 + mag_d) / (mag_d * 2);
    m     = (q > LimitMag) ? LimitMag : $signed(q[63:0]);
    return neg ? -m : m;
  endfunction

  function automatic bit within_span(logic signed [63:0] v, logic signed [63:0] a,
                                     logic signed [63:0] b, logic signed [63:0] tol);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (v >= lo - tol) && (v <= hi + tol);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return CoordMax;
    if (v < -64'sd2147483648) return CoordMin;
    return v[31:0];
  endfunction

  function automatic out_t predict_crossing(in_t s, logic [30:0] tol_reg);
    wide_t ax0, ay0, bx0, by0, ax1, ay1, bx1, by1;
    wide_t dx0, dy0, dx1, dy1, e0, e1, det;
    logic signed [63:0] x, y, tol;
    out_t r;
    ax0 = s.seg0_ax; ay0 = s.seg0_ay; bx0 = s.seg0_bx; by0 = s.seg0_by;
    ax1 = s.seg1_ax; ay1 = s.seg1_ay; bx1 = s.seg1_bx; by1 = s.seg1_by;
    dx0 = bx0 - ax0; dy0 = by0 - ay0;
    dx1 = bx1 - ax1; dy1 = by1 - ay1;
    e0  = dy0 * ax0 - dx0 * ay0;
    e1  = dy1 * ax1 - dx1 * ay1;
    det = dx0 * dy1 - dy0 * dx1;
    r   = '0;
    if (det == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    x   = round_quotient(dx0 * e1 - dx1 * e0, det);
    y   = round_quotient(dy0 * e1 - dy1 * e0, det);
    tol = {33'b0, tol_reg};
    r.hit = within_span(x, 64'(ax0), 64'(bx0), tol) &&
            within_span(x, 64'(ax1), 64'(bx1), tol) &&
            within_span(y, 64'(ay0), 64'(by0), tol) &&
            within_span(y, 64'(ay1), 64'(by1), tol);
    r.cross_x = clamp32(x);
    r.cross_y = clamp32(y);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest
  // expectation, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_data_o.hit) hits_seen++;
      if (out_data_o.parallel) parallels_seen++;
      if (expected_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected: %p", out_data_o);
      end else begin
        want = expected_crossings.pop_front();
        if (out_data_o.hit !== want.hit || out_data_o.cross_x !== want.cross_x ||
            out_data_o.cross_y !== want.cross_y ||
            out_data_o.parallel !== want.parallel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected hit=%0b x=%0d y=%0d par=%0b, got hit=%0b x=%0d y=%0d par=%0b",
                     results_seen, want.hit, want.cross_x, want.cross_y, want.parallel,
                     out_data_o.hit, out_data_o.cross_x, out_data_o.cross_y,
                     out_data_o.parallel);
        end
      end
    end
  end

  // Receiver: random stalls about a quarter of the time, plus the long
  // hold-off, which this process counts on its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_ack    <= 0;
      hold_left   <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_idle_en && ($urandom_range(99) < 25);
    end
  end

  // Watchdog: any cycle without a transfer on any channel counts toward
  // the limit, which is far above the longest legal hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("ERROR: watchdog expired with %0d results outstanding",
                 expected_crossings.size());
        $display("segment_segment_intersect_core test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Offers one segment pair and waits for its transfer. An optional gap is
  // inserted first; valid stays high afterwards so back-to-back items flow.
  task automatic send_pair(in_t s);
    int unsigned gap;
    if (send_idle_en && ($urandom_range(99) < 25)) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_crossings.push_back(predict_crossing(s, tol_shadow));
    items_sent++;
  endtask

  // Waits until every expected result has come back, then lets the pipeline
  // run empty for its full depth.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_crossings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Tolerance write; only called with the pipeline drained.
  task automatic write_tolerance(logic [30:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tol_shadow = value;
  endtask

  function automatic in_t make_pair(logic signed [31:0] a0x, logic signed [31:0] a0y,
                                    logic signed [31:0] b0x, logic signed [31:0] b0y,
                                    logic signed [31:0] a1x, logic signed [31:0] a1y,
                                    logic signed [31:0] b1x, logic signed [31:0] b1y);
    in_t s;
    s.seg0_ax = a0x; s.seg0_ay = a0y; s.seg0_bx = b0x; s.seg0_by = b0y;
    s.seg1_ax = a1x; s.seg1_ay = a1y; s.seg1_bx = b1x; s.seg1_by = b1y;
    return s;
  endfunction

  // Random pair. Most are crossing layouts that reach the containment
  // test; the rest are full-range noise, parallel, axis-aligned and degenerate.
  function automatic in_t random_pair();
    in_t s;
    int unsigned kind;
    int unsigned span;
    logic signed [31:0] dx, dy, k;
    kind = $urandom_range(99);
    span = ($urandom_range(3) == 0) ? 32'h3FFF_FFFF : 32'h0008_0000;
    s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind < 60) begin
      // Two segments around a shared region, each coordinate scattered.
      s.seg0_ax = $signed($urandom_range(span)) - $signed(span / 2);
      s.seg0_ay = $signed($urandom_range(span)) - $signed(span / 2);
      s.seg0_bx = -s.seg0_ax + $signed($urandom_range(255)) - 128;
      s.seg0_by = -s.seg0_ay + $signed($urandom_range(255)) - 128;
      s.seg1_ax = $signed($urandom_range(span)) - $signed(span / 2);
      s.seg1_ay = -$signed($urandom_range(span)) + $signed(span / 2);
      s.seg1_bx = -s.seg1_ax + $signed($urandom_range(255)) - 128;
      s.seg1_by = -s.seg1_ay + $signed($urandom_range(255)) - 128;
    end else if (kind < 70) begin
      // Parallel: the second segment is a scaled, shifted copy of the first.
      dx = $signed($urandom_range(4095)) - 2048;
      dy = $signed($urandom_range(4095)) - 2048;
      k  = $signed($urandom_range(7)) - 3;
      s.seg0_bx = s.seg0_ax / 4 + dx; s.seg0_ax = s.seg0_ax / 4;
      s.seg0_by = s.seg0_ay / 4 + dy; s.seg0_ay = s.seg0_ay / 4;
      s.seg1_ax = s.seg1_ax / 4;      s.seg1_ay = s.seg1_ay / 4;
      s.seg1_bx = s.seg1_ax + k * dx; s.seg1_by = s.seg1_ay + k * dy;
    end else if (kind < 78) begin
      // Vertical or horizontal segments.
      s.seg0_bx = s.seg0_ax;
      if ($urandom_range(1)) s.seg1_bx = s.seg1_ax;
      else s.seg1_by = s.seg1_ay;
    end else if (kind < 82) begin
      // Degenerate first segment.
      s.seg0_bx = s.seg0_ax;
      s.seg0_by = s.seg0_ay;
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Hand-picked cases: extremes, crossings, ties, parallel and vertical lines,
  // reversed endpoints and saturation.
  task automatic test_directed_cases();
    // Plain crossing of two diagonals at the origin, and with endpoints swapped.
    send_pair(make_pair(-65536, -65536, 65536, 65536, -65536, 65536, 65536, -65536));
    send_pair(make_pair(65536, 65536, -65536, -65536, 65536, -65536, -65536, 65536));
    // Rounding ties at +1/2 and -1/2 grid steps.
    send_pair(make_pair(0, 0, 1, 1, 0, 1, 1, 0));
    send_pair(make_pair(0, 0, -1, -1, 0, -1, -1, 0));
    // Vertical against horizontal, vertical against sloped.
    send_pair(make_pair(100, -500, 100, 500, -500, 7, 500, 7));
    send_pair(make_pair(100, -500, 100, 500, -300, -300, 300, 301));
    // Two verticals, equal slopes, collinear and degenerate segments.
    send_pair(make_pair(5, 0, 5, 9, 8, 1, 8, -4));
    send_pair(make_pair(0, 0, 10, 20, 3, 0, 13, 20));
    send_pair(make_pair(0, 0, 10, 20, 20, 40, 30, 60));
    send_pair(make_pair(3, 3, 3, 3, 0, 0, 9, 1));
    // Lines that cross just outside one segment: only a tolerance hides it.
    send_pair(make_pair(0, 0, 100, 0, 101, -50, 101, 50));
    // An exactly parallel pair, then shallow lines that cross a horizontal at x = +-2^20.
    send_pair(make_pair(0, 0, 1 << 20, 1, 0, 1, 1 << 20, 2 + 0));
    send_pair(make_pair(0, 0, 1 << 20, 1, 0, 1, (1 << 20) + 1, 1));
    send_pair(make_pair(0, 0, -(1 << 20), 1, 0, 1, -(1 << 20) - 1, 1));
    // Coordinate extremes.
    send_pair(make_pair(CoordMin, CoordMin, CoordMax, CoordMax,
                        CoordMin, CoordMax, CoordMax, CoordMin));
    send_pair(make_pair(CoordMax, CoordMin, CoordMin, CoordMax,
                        CoordMin, CoordMin, CoordMax, CoordMax));
    send_pair(make_pair(CoordMin, CoordMin, CoordMax, CoordMin,
                        CoordMin, CoordMin, CoordMin, CoordMax));
    send_pair(make_pair(CoordMax, CoordMax, CoordMax, CoordMin,
                        CoordMin, CoordMax, CoordMax, CoordMax));
    send_pair(make_pair(CoordMin, CoordMax, CoordMax, CoordMin,
                        CoordMin, CoordMax + 0, CoordMax, CoordMin + 1));
    send_pair(make_pair(CoordMin, 0, CoordMax, 1, 0, CoordMin, 1, CoordMax));
    drain_pipeline();
  endtask

  // Random pairs under random idling on both sides.
  task automatic test_random_pairs(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pair(random_pair());
    drain_pipeline();
  endtask

  // Random pairs with no idling on either side, at full rate.
  task automatic test_full_rate(int unsigned count);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (int unsigned i = 0; i < count; i++) send_pair(random_pair());
    drain_pipeline();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // The receiver holds off long enough that the pipeline fills and stalls the
  // input, while the sender keeps offering; then the sender waits until every
  // expected result has come before offering more.
  task automatic test_backpressure(int unsigned count);
    hold_req++;
    for (int unsigned i = 0; i < count; i++) send_pair(random_pair());
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_crossings.size() != 0) @(posedge clk_i);
    for (int unsigned i = 0; i < 10; i++) send_pair(random_pair());
    drain_pipeline();
  endtask

  // Sweeps the tolerance register through its extremes and random values,
  // running directed and random pairs at each setting.
  task automatic test_tolerance_sweep();
    logic [30:0] settings[5];
    settings[0] = TolMax;
    settings[1] = TolOne;
    settings[2] = 31'd1;
    settings[3] = 31'($urandom);
    settings[4] = 31'd0;
    foreach (settings[i]) begin
      write_tolerance(settings[i]);
      for (int unsigned j = 0; j < 8; j++)
        send_pair(make_pair(0, 0, 100, 0, 100 + j * 40000, -50, 100 + j * 40000, 50));
      test_random_pairs(20);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    tol_shadow   = '0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    hits_seen    = 0;
    parallels_seen = 0;
    idle_cycles  = 0;
    hold_req     = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    write_tolerance(TolOne);
    test_directed_cases();
    write_tolerance(31'd0);
    test_random_pairs(120);
    test_full_rate(80);
    test_backpressure(120);
    test_tolerance_sweep();

    $display("Run covered %0d segment pairs and %0d results (%0d hits, %0d parallel),",
             items_sent, results_seen, hits_seen, parallels_seen);
    $display("across five tolerance settings, full-rate bursts and a long output hold-off.");
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("segment_segment_intersect_core test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_crossings.size());
      $display("segment_segment_intersect_core test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/segint_pkg.sv
sv/segint_front.sv
sv/segint_div_step.sv
sv/segint_back.sv
sv/segment_segment_intersect_core.sv
bench/segment_segment_intersect_core_test.sv
